[design/tzdc_pkg.sv]
package tzdc_pkg;

  localparam int unsigned MinPerDay  = 1440;
  localparam int unsigned MinPerHour = 60;
  localparam int unsigned YearMax    = 9999;

  // configuration register indexes
  localparam logic [2:0] REG_SRC_STD   = 3'd0;
  localparam logic [2:0] REG_SRC_DST   = 3'd1;
  localparam logic [2:0] REG_SRC_START = 3'd2;
  localparam logic [2:0] REG_SRC_END   = 3'd3;
  localparam logic [2:0] REG_DST_STD   = 3'd4;
  localparam logic [2:0] REG_DST_DST   = 3'd5;
  localparam logic [2:0] REG_DST_START = 3'd6;
  localparam logic [2:0] REG_DST_END   = 3'd7;

  typedef struct packed {
    logic signed [10:0] src_std_offset;
    logic signed [10:0] src_dst_offset;
    logic [8:0]         src_window_start;
    logic [8:0]         src_window_end;
    logic signed [10:0] dst_std_offset;
    logic signed [10:0] dst_dst_offset;
    logic [8:0]         dst_window_start;
    logic [8:0]         dst_window_end;
  } cfg_t;

  // item in flight: minute of day and date, leap flag of the input year
  typedef struct packed {
    logic [10:0] tod;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        leap;
  } date_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } res_t;

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m) inside
      4'd2:                     n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  n = 5'd30;
      default:                  n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic in_window(input logic [8:0] start, input logic [8:0] stop,
                                     input logic [4:0] d, input logic [3:0] m);
    logic [8:0] key;
    logic       hit;
    key = {m, d};
    if (start[8:5] == 4'd0) begin
      hit = 1'b0;
    end else if (start <= stop) begin
      hit = (key >= start) && (key <= stop);
    end else begin
      hit = (key >= start) || (key <= stop);
    end
    return hit;
  endfunction

  // leap only matters around february, where the year never changes
  function automatic date_t day_fwd(input date_t a);
    date_t r;
    r = a;
    if (a.day < days_in(a.month, a.leap)) begin
      r.day = a.day + 5'd1;
    end else begin
      r.day = 5'd1;
      if (a.month < 4'd12) begin
        r.month = a.month + 4'd1;
      end else begin
        r.month = 4'd1;
        r.year  = (a.year >= 14'(YearMax)) ? 14'd0 : a.year + 14'd1;
      end
    end
    return r;
  endfunction

  function automatic date_t day_back(input date_t a);
    date_t r;
    r = a;
    if (a.day > 5'd1) begin
      r.day = a.day - 5'd1;
    end else if (a.month > 4'd1) begin
      r.month = a.month - 4'd1;
      r.day   = days_in(a.month - 4'd1, a.leap);
    end else begin
      r.month = 4'd12;
      r.day   = 5'd31;
      r.year  = (a.year == 14'd0) ? 14'(YearMax) : a.year - 14'd1;
    end
    return r;
  endfunction

endpackage

[design/tzdc_if.sv]
interface tzdc_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [4:0]  in_day;
  logic [3:0]  in_month;
  logic [13:0] in_year;

  modport source (output valid, in_hour, in_minute, in_day, in_month, in_year,
                  input ready);
  modport sink (input valid, in_hour, in_minute, in_day, in_month, in_year,
                output ready);
endinterface

interface tzdc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;

  modport source (output valid, out_hour, out_minute, out_day, out_month, out_year,
                  input ready);
  modport sink (input valid, out_hour, out_minute, out_day, out_month, out_year,
                output ready);
endinterface

interface tzdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/tzdc_front.sv]
module tzdc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [4:0]       hour,
  input  logic [5:0]       minute,
  input  logic [4:0]       day,
  input  logic [3:0]       month,
  input  logic [13:0]      year,
  output logic             out_valid,
  output tzdc_pkg::date_t  out_date
);
  import tzdc_pkg::*;

  logic [4:0]  h_c;
  logic [5:0]  mi_c;
  logic [3:0]  m_c;
  logic [13:0] y_c;
  logic [26:0] y_prod;

  logic        v1;
  logic [10:0] tod1;
  logic [4:0]  day1;
  logic [3:0]  month1;
  logic [13:0] year1;
  logic [6:0]  cent1;

  logic [13:0] rem100;
  logic        leap;
  logic [4:0]  lim;
  logic [4:0]  d_c;

  // stage 1: saturate fields, minute of day, year / 100 by reciprocal
  always_comb begin
    h_c    = (hour > 5'd23) ? 5'd23 : hour;
    mi_c   = (minute > 6'd59) ? 6'd59 : minute;
    m_c    = (month == 4'd0) ? 4'd1 : ((month > 4'd12) ? 4'd12 : month);
    y_c    = (year > 14'(YearMax)) ? 14'(YearMax) : year;
    y_prod = 27'(y_c) * 27'd5243;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tod1   <= 11'({h_c, 6'd0}) - 11'({h_c, 2'd0}) + 11'(mi_c);
      day1   <= day;
      month1 <= m_c;
      year1  <= y_c;
      cent1  <= y_prod[25:19];
    end
  end

  // stage 2: gregorian leap flag and day clamp
  always_comb begin
    rem100 = year1 - 14'(cent1) * 14'd100;
    leap   = ((year1[1:0] == 2'd0) && (rem100 != 14'd0)) ||
             ((rem100 == 14'd0) && (cent1[1:0] == 2'd0));
    lim    = days_in(month1, leap);
    d_c    = (day1 == 5'd0) ? 5'd1 : ((day1 > lim) ? lim : day1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_date.tod   <= tod1;
      out_date.day   <= d_c;
      out_date.month <= month1;
      out_date.year  <= year1;
      out_date.leap  <= leap;
    end
  end

endmodule

[design/tzdc_shift.sv]
module tzdc_shift (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               sub,
  input  logic signed [10:0] std_off,
  input  logic signed [10:0] dst_off,
  input  logic [8:0]         win_start,
  input  logic [8:0]         win_end,
  input  logic               in_valid,
  input  tzdc_pkg::date_t    in_date,
  output logic               out_valid,
  output tzdc_pkg::date_t    out_date
);
  import tzdc_pkg::*;

  logic signed [10:0] off;
  logic signed [12:0] tod_s;
  logic signed [12:0] off_s;

  logic               v1;
  logic signed [12:0] sum1;
  date_t              date1;
  date_t              wrapped;

  // stage 1: pick offset on the current date, apply it
  always_comb begin
    off   = in_window(win_start, win_end, in_date.day, in_date.month) ? dst_off : std_off;
    tod_s = $signed({2'b00, in_date.tod});
    off_s = 13'(off);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1  <= sub ? (tod_s - off_s) : (tod_s + off_s);
      date1 <= in_date;
    end
  end

  // stage 2: one wrap of a day at most
  always_comb begin
    if (sum1 < 13'sd0) begin
      wrapped     = day_back(date1);
      wrapped.tod = 11'(sum1 + 13'sd1440);
    end else if (sum1 >= 13'sd1440) begin
      wrapped     = day_fwd(date1);
      wrapped.tod = 11'(sum1 - 13'sd1440);
    end else begin
      wrapped     = date1;
      wrapped.tod = 11'(sum1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_date <= wrapped;
    end
  end

endmodule

[design/tzdc_split.sv]
module tzdc_split (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  tzdc_pkg::date_t  in_date,
  output logic             out_valid,
  output tzdc_pkg::res_t   out_res
);
  import tzdc_pkg::*;

  logic [21:0] hr_prod;
  logic        v1;
  logic [4:0]  hour1;
  date_t       date1;

  // minute of day / 60 by reciprocal, exact below 1440
  assign hr_prod = 22'(in_date.tod) * 22'd2185;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hour1 <= hr_prod[21:17];
      date1 <= in_date;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res.hour   <= hour1;
      out_res.minute <= 6'(date1.tod - 11'(hour1) * 11'(MinPerHour));
      out_res.day    <= date1.day;
      out_res.month  <= date1.month;
      out_res.year   <= date1.year;
    end
  end

endmodule

[design/timezone_dst_time_converter_unit.sv]
// Time-zone converter with daylight saving.
// din carries a source local hour, minute, day, month and year; dout returns
// the same instant as destination local time and date, one result per item.
// cfg writes the zone registers (index 0..7: source standard and daylight
// offsets, source window start and end, then the same four for the
// destination); it is always ready. The user must write it only while the
// block is idle; the block does not enforce this. Out-of-range input fields
// are saturated before use, years wrap 9999 <-> 0. An item passes the front
// end (clamp and leap), source shift and wrap, destination shift and wrap and
// hour and minute split on its way to dout, two register stages each.
// Throughput: one item per cycle while dout is taken.
// The whole pipeline advances as one; when dout is stalled every stage holds
// and din.ready drops, so no item is lost or repeated.
// Reset clears all valid bits and sets every zone register to zero.
module timezone_dst_time_converter_unit (
  input logic       clk,
  input logic       rst,
  tzdc_in_if.sink   din,
  tzdc_out_if.source dout,
  tzdc_cfg_if.sink  cfg
);
  import tzdc_pkg::*;

  cfg_t  regs;
  logic  adv;

  logic  fr_valid;
  date_t fr_date;
  logic  s1_valid;
  date_t s1_date;
  logic  s2_valid;
  date_t s2_date;
  logic  sp_valid;
  res_t  sp_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SRC_STD:   regs.src_std_offset   <= cfg.data;
        REG_SRC_DST:   regs.src_dst_offset   <= cfg.data;
        REG_SRC_START: regs.src_window_start <= cfg.data[8:0];
        REG_SRC_END:   regs.src_window_end   <= cfg.data[8:0];
        REG_DST_STD:   regs.dst_std_offset   <= cfg.data;
        REG_DST_DST:   regs.dst_dst_offset   <= cfg.data;
        REG_DST_START: regs.dst_window_start <= cfg.data[8:0];
        REG_DST_END:   regs.dst_window_end   <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished result is waiting
  assign adv       = !sp_valid || dout.ready;
  assign din.ready = adv;

  tzdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (din.valid),
    .hour      (din.in_hour),
    .minute    (din.in_minute),
    .day       (din.in_day),
    .month     (din.in_month),
    .year      (din.in_year),
    .out_valid (fr_valid),
    .out_date  (fr_date)
  );

  tzdc_shift u_src (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .sub       (1'b1),
    .std_off   (regs.src_std_offset),
    .dst_off   (regs.src_dst_offset),
    .win_start (regs.src_window_start),
    .win_end   (regs.src_window_end),
    .in_valid  (fr_valid),
    .in_date   (fr_date),
    .out_valid (s1_valid),
    .out_date  (s1_date)
  );

  tzdc_shift u_dst (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .sub       (1'b0),
    .std_off   (regs.dst_std_offset),
    .dst_off   (regs.dst_dst_offset),
    .win_start (regs.dst_window_start),
    .win_end   (regs.dst_window_end),
    .in_valid  (s1_valid),
    .in_date   (s1_date),
    .out_valid (s2_valid),
    .out_date  (s2_date)
  );

  tzdc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s2_valid),
    .in_date   (s2_date),
    .out_valid (sp_valid),
    .out_res   (sp_res)
  );

  assign dout.valid      = sp_valid;
  assign dout.out_hour   = sp_res.hour;
  assign dout.out_minute = sp_res.minute;
  assign dout.out_day    = sp_res.day;
  assign dout.out_month  = sp_res.month;
  assign dout.out_year   = sp_res.year;

`ifndef SYNTHESIS
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.out_hour <= 5'd23) && (dout.out_minute <= 6'd59))
    else $error("result time of day out of range");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.out_month >= 4'd1) && (dout.out_month <= 4'd12) &&
                   (dout.out_day >= 5'd1) &&
                   (dout.out_day <= days_in(dout.out_month, 1'b1)))
    else $error("result date out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.out_year <= 14'(YearMax)))
    else $error("result year out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !adv) |=> s2_valid && $stable(s2_date))
    else $error("pipeline stage changed during stall");
`endif

endmodule
